// ----- rtl/core/mbe_pkg.sv -----
// Shared types, constants and helpers for the Mandelbrot escape-time unit.
// The point former, the iteration ring, the top level and the testbench use it.
// It depends on nothing else.
package mbe_pkg;

  // Fixed-point format and field widths.
  localparam int unsigned FracBits = 27;
  localparam int unsigned IdxW     = 12;
  localparam int unsigned WordW    = 32;
  localparam int unsigned LimW     = 16;
  localparam int unsigned CntW     = 17;
  localparam int unsigned RadW     = 31;
  localparam int unsigned ProdW    = 64;
  // Width of a shifted square term: a 63-bit magnitude shifted down by 26 or more bits.
  localparam int unsigned ShW      = 38;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegOriginRe = 3'd0;
  localparam logic [2:0] RegOriginIm = 3'd1;
  localparam logic [2:0] RegStepRe   = 3'd2;
  localparam logic [2:0] RegStepIm   = 3'd3;
  localparam logic [2:0] RegLimit    = 3'd4;
  localparam logic [2:0] RegRadius   = 3'd5;

  // Reset values of the registers.
  localparam logic [31:0] RstOriginRe = 32'hF000_0000;
  localparam logic [31:0] RstOriginIm = 32'hF400_0000;
  localparam logic [31:0] RstStepRe   = 32'h0006_0000;
  localparam logic [31:0] RstStepIm   = 32'h0006_0000;
  localparam logic [15:0] RstLimit    = 16'd255;
  localparam logic [30:0] RstRadius   = 31'h2000_0000;

  // Saturation bounds for the signed 32-bit range.
  localparam logic signed [47:0] SatHi = 48'sd2147483647;
  localparam logic signed [47:0] SatLo = -48'sd2147483648;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic signed [WordW-1:0] origin_re;
    logic signed [WordW-1:0] origin_im;
    logic signed [WordW-1:0] step_re;
    logic signed [WordW-1:0] step_im;
    logic [LimW-1:0]         limit;
    logic [RadW-1:0]         radius;
  } cfg_t;

  // One pixel in flight.
  typedef struct packed {
    logic [IdxW-1:0]         col;
    logic [IdxW-1:0]         row;
    logic signed [WordW-1:0] c_re;
    logic signed [WordW-1:0] c_im;
    logic signed [WordW-1:0] x;
    logic signed [WordW-1:0] y;
    logic [CntW-1:0]         n;
    logic                    done;
    logic                    esc;
  } slot_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SatHi) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SatLo) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/mbe_point.sv -----
// Point former: c = origin + index * step per axis, saturated, over two stages.
// Depends on mbe_pkg.
module mbe_point (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbe_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [11:0]         in_col_i,
  input  logic [11:0]         in_row_i,
  output logic                pt_valid_o,
  input  logic                pt_take_i,
  output mbe_pkg::slot_t      pt_o
);

  logic                 e1_v_q;
  logic [11:0]          e1_col_q, e1_row_q;
  logic signed [44:0]   e1_pre_q, e1_pim_q;
  logic signed [44:0]   pre_d, pim_d;
  logic                 e2_v_q;
  mbe_pkg::slot_t       e2_q, e2_d;
  logic                 e2_free, e1_free;

  // Flow control: a stage moves on when the one after it is free.
  assign e2_free    = !e2_v_q || pt_take_i;
  assign e1_free    = !e1_v_q || e2_free;
  assign in_ready_o = e1_free;

  // First stage: index times step.
  assign pre_d = $signed({1'b0, in_col_i}) * cfg_i.step_re;
  assign pim_d = $signed({1'b0, in_row_i}) * cfg_i.step_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
    end else if (e1_free) begin
      e1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e1_free && in_valid_i) begin
      e1_col_q <= in_col_i;
      e1_row_q <= in_row_i;
      e1_pre_q <= pre_d;
      e1_pim_q <= pim_d;
    end
  end

  // Second stage: add the origin, saturate, start the orbit at z = c.
  always_comb begin
    e2_d      = '0;
    e2_d.col  = e1_col_q;
    e2_d.row  = e1_row_q;
    e2_d.c_re = mbe_pkg::sat32({{3{e1_pre_q[44]}}, e1_pre_q}
                               + {{16{cfg_i.origin_re[31]}}, cfg_i.origin_re});
    e2_d.c_im = mbe_pkg::sat32({{3{e1_pim_q[44]}}, e1_pim_q}
                               + {{16{cfg_i.origin_im[31]}}, cfg_i.origin_im});
    e2_d.x    = e2_d.c_re;
    e2_d.y    = e2_d.c_im;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_v_q <= 1'b0;
    end else if (e2_free) begin
      e2_v_q <= e1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e2_free && e1_v_q) begin
      e2_q <= e2_d;
    end
  end

  assign pt_valid_o = e2_v_q;
  assign pt_o       = e2_q;

endmodule

// ----- rtl/core/mbe_ring.sv -----
// Iteration ring: three stages (square, escape test and shift, add and saturate)
// closed into a loop, so up to three pixels iterate at once; results leave in
// arrival order. Depends on mbe_pkg.
module mbe_ring (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbe_pkg::cfg_t       cfg_i,
  input  logic                new_valid_i,
  output logic                new_take_o,
  input  mbe_pkg::slot_t      new_i,
  input  logic                res_free_i,
  output logic                res_valid_o,
  output mbe_pkg::slot_t      res_o
);

  // Stage registers.
  logic                                a_v_q, b_v_q, c_v_q;
  mbe_pkg::slot_t                      a_s_q, b_s_q, c_s_q;
  mbe_pkg::slot_t                      a_d, c_d;
  logic signed [mbe_pkg::ProdW-1:0]    xx_q, yy_q, xy_q;
  logic signed [mbe_pkg::ProdW-1:0]    xx_d, yy_d, xy_d;
  logic                                hit_q, hit_d;
  logic signed [mbe_pkg::ShW-1:0]      re_q, im_q, re_d, im_d;
  logic [mbe_pkg::ProdW-1:0]           sum, thr;
  logic signed [mbe_pkg::ProdW-1:0]    diff, dsh, psh;
  logic                                exit_w, slot_free, a_v_d;
  logic [1:0]                          head_q, tail_q;
  logic [1:0]                          a_t_q, b_t_q, c_t_q, a_t_d;

  // A finished pixel leaves the loop when it is the oldest one in the ring and
  // the output register can take it; otherwise it keeps circulating unchanged.
  assign exit_w      = c_v_q && c_s_q.done && (c_t_q == head_q) && res_free_i;
  assign slot_free   = !c_v_q || exit_w;
  assign new_take_o  = slot_free && new_valid_i;
  assign res_valid_o = exit_w;
  assign res_o       = c_s_q;

  // Loop entry: a new pixel fills an empty slot, else the last stage feeds back.
  assign a_d   = new_take_o ? new_i : c_s_q;
  assign a_v_d = new_take_o || (c_v_q && !exit_w);
  assign a_t_d = new_take_o ? tail_q : c_t_q;

  // Arrival tags: the tail numbers each new pixel, the head names the oldest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 2'd0;
      tail_q <= 2'd0;
    end else begin
      if (exit_w) begin
        head_q <= head_q + 2'd1;
      end
      if (new_take_o) begin
        tail_q <= tail_q + 2'd1;
      end
    end
  end

  // Stage A: the three products.
  assign xx_d = a_d.x * a_d.x;
  assign yy_d = a_d.y * a_d.y;
  assign xy_d = a_d.x * a_d.y;

  // Stage B: full-width escape test and floor shifts of the update terms.
  assign sum  = xx_q + yy_q;
  assign thr  = {{(mbe_pkg::ProdW - mbe_pkg::RadW){1'b0}}, cfg_i.radius} << mbe_pkg::FracBits;
  assign hit_d = sum > thr;
  assign diff = xx_q - yy_q;
  assign dsh  = diff >>> mbe_pkg::FracBits;
  assign psh  = xy_q >>> (mbe_pkg::FracBits - 1);
  assign re_d = dsh[mbe_pkg::ShW-1:0];
  assign im_d = psh[mbe_pkg::ShW-1:0];

  // Stage C: escape decision, or z = z^2 + c and the count.
  always_comb begin
    c_d = b_s_q;
    if (!b_s_q.done) begin
      if (hit_q) begin
        c_d.done = 1'b1;
        c_d.esc  = 1'b1;
      end else begin
        c_d.x = mbe_pkg::sat32({{10{re_q[mbe_pkg::ShW-1]}}, re_q}
                               + {{16{b_s_q.c_re[31]}}, b_s_q.c_re});
        c_d.y = mbe_pkg::sat32({{10{im_q[mbe_pkg::ShW-1]}}, im_q}
                               + {{16{b_s_q.c_im[31]}}, b_s_q.c_im});
        c_d.n = b_s_q.n + 17'd1;
        if (b_s_q.n == {1'b0, cfg_i.limit}) begin
          c_d.done = 1'b1;
        end
      end
    end
  end

  // Valid bits travel round the loop with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      a_v_q <= a_v_d;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_s_q <= a_d;
    a_t_q <= a_t_d;
    xx_q  <= xx_d;
    yy_q  <= yy_d;
    xy_q  <= xy_d;
    b_s_q <= a_s_q;
    b_t_q <= a_t_q;
    hit_q <= hit_d;
    re_q  <= re_d;
    im_q  <= im_d;
    c_s_q <= c_d;
    c_t_q <= b_t_q;
  end

endmodule

// ----- rtl/core/mandelbrot_escape_time_unit.sv -----
// Top level of the Mandelbrot escape-time unit: registers, point former,
// iteration ring and output register. Depends on mbe_pkg, mbe_point, mbe_ring.
//
//   Channel   Direction  Beat contents
//   s_axis    in         column [11:0], row [23:12]
//   m_axis    out        out_column [11:0], out_row [23:12], iterations [40:24],
//                        escaped [41], zero [47:42]
//   apb       in/out     six registers at byte addresses 0, 4, ..., 20
//
// A pixel passes through the point former, then goes round the three-stage loop
// through the squaring multipliers n+1 times if it escapes after n tests, or n
// times if it reaches the limit (n = limit + 1), plus any rounds spent waiting
// behind an older pixel, then passes through the output register. The ring holds
// three pixels, so a pixel that does not escape occupies one of three loop slots
// until it reaches the limit. Reset clears all valid bits and restores the
// register defaults. A stalled output, or an older pixel still iterating, keeps
// finished pixels circulating in the ring; input is then refused once no slot is
// free. Results leave in arrival order.
module mandelbrot_escape_time_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // column [11:0], row [23:12]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // out_column, out_row, iterations, escaped, pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mbe_pkg::cfg_t   cfg_q;
  logic [2:0]      reg_idx;
  logic            wr_en;
  logic            pt_valid, pt_take, res_valid, out_free;
  mbe_pkg::slot_t  pt_slot, res_slot;
  logic            m_valid_q;
  logic [47:0]     m_data_q;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_re <= mbe_pkg::RstOriginRe;
      cfg_q.origin_im <= mbe_pkg::RstOriginIm;
      cfg_q.step_re   <= mbe_pkg::RstStepRe;
      cfg_q.step_im   <= mbe_pkg::RstStepIm;
      cfg_q.limit     <= mbe_pkg::RstLimit;
      cfg_q.radius    <= mbe_pkg::RstRadius;
    end else if (wr_en) begin
      case (reg_idx)
        mbe_pkg::RegOriginRe: cfg_q.origin_re <= pwdata;
        mbe_pkg::RegOriginIm: cfg_q.origin_im <= pwdata;
        mbe_pkg::RegStepRe:   cfg_q.step_re   <= pwdata;
        mbe_pkg::RegStepIm:   cfg_q.step_im   <= pwdata;
        mbe_pkg::RegLimit:    cfg_q.limit     <= pwdata[15:0];
        mbe_pkg::RegRadius:   cfg_q.radius    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      mbe_pkg::RegOriginRe: prdata = cfg_q.origin_re;
      mbe_pkg::RegOriginIm: prdata = cfg_q.origin_im;
      mbe_pkg::RegStepRe:   prdata = cfg_q.step_re;
      mbe_pkg::RegStepIm:   prdata = cfg_q.step_im;
      mbe_pkg::RegLimit:    prdata = {16'd0, cfg_q.limit};
      mbe_pkg::RegRadius:   prdata = {1'b0, cfg_q.radius};
      default:              prdata = 32'd0;
    endcase
  end

  mbe_point u_point (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_col_i   (s_axis_tdata_i[11:0]),
    .in_row_i   (s_axis_tdata_i[23:12]),
    .pt_valid_o (pt_valid),
    .pt_take_i  (pt_take),
    .pt_o       (pt_slot)
  );

  mbe_ring u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .new_valid_i (pt_valid),
    .new_take_o  (pt_take),
    .new_i       (pt_slot),
    .res_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res_slot)
  );

  // Output register: holds a result beat until the sink takes it.
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      m_data_q <= {6'd0, res_slot.esc, res_slot.n, res_slot.row, res_slot.col};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ----- rtl/core/mbe_checker.sv -----
// Port-level checker for the Mandelbrot escape-time unit, bound to the top level.
// Depends only on the top level's ports.
module mbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o
);

  // A result beat, once shown, stays until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // A pixel that did not escape has survived at least one test.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[41] |-> m_axis_tdata_o[40:24] != 17'd0)
    else $error("non-escaped pixel with zero iterations");

  // The padding bits of a result beat are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[47:42] == 6'd0)
    else $error("result padding not zero");

  // The iteration count never goes beyond the largest limit plus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[40:24] <= 17'h1_0000)
    else $error("iteration count out of range");

endmodule

bind mandelbrot_escape_time_unit mbe_checker u_mbe_checker (.*);

// ----- test/mandelbrot_escape_time_unit_tb.sv -----
// Self-checking testbench for the Mandelbrot escape-time unit.
// Pixels are streamed in through a queue-fed driver and predicted in the testbench;
// results are checked by a monitor. Depends on mbe_pkg and mandelbrot_escape_time_unit.
module mandelbrot_escape_time_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [mbe_pkg::IdxW-1:0] row;
    logic [mbe_pkg::IdxW-1:0] col;
  } pixel_t;

  typedef struct packed {
    logic                     esc;
    logic [mbe_pkg::CntW-1:0] iters;
    logic [mbe_pkg::IdxW-1:0] row;
    logic [mbe_pkg::IdxW-1:0] col;
  } escape_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // column [11:0], row [23:12]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;   // out_column [11:0], out_row [23:12], iterations [40:24],
                                 // escaped [41], zero [47:42]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Local copy of the register file.
  logic signed [31:0]       org_re, org_im, stp_re, stp_im;
  logic [mbe_pkg::LimW-1:0] iter_limit;
  logic [mbe_pkg::RadW-1:0] radius_sq;

  pixel_t  pixel_queue[$];
  escape_t escape_queue[$];
  int      mismatches;
  bit      no_idle;
  int      in_gap;
  int      out_gap;

  mandelbrot_escape_time_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Clamp to the signed 32-bit range.
  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Escape-time count of one pixel under the current register settings.
  function automatic escape_t predict_escape(pixel_t px);
    longint      cre, cim, x, y, xx, yy, xy;
    logic [63:0] mag, thr;
    int unsigned n;
    bit          esc;
    escape_t     r;
    cre = clamp_word(longint'(org_re) + longint'(px.col) * longint'(stp_re));
    cim = clamp_word(longint'(org_im) + longint'(px.row) * longint'(stp_im));
    x   = cre;
    y   = cim;
    esc = 1'b0;
    thr = 64'(radius_sq) << mbe_pkg::FracBits;
    for (n = 0; n <= iter_limit; n++) begin
      xx  = x * x;
      yy  = y * y;
      xy  = x * y;
      mag = 64'(xx) + 64'(yy);
      if (mag > thr) begin
        esc = 1'b1;
        break;
      end
      x = clamp_word(((xx - yy) >>> mbe_pkg::FracBits) + cre);
      y = clamp_word((xy >>> (mbe_pkg::FracBits - 1)) + cim);
    end
    r.col   = px.col;
    r.row   = px.row;
    r.iters = n[mbe_pkg::CntW-1:0];
    r.esc   = esc;
    return r;
  endfunction

  // Driver: feeds pixel beats from the queue, with random idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      in_gap          <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        escape_queue.push_back(predict_escape(pixel_t'(s_axis_tdata_i)));
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (in_gap > 0) begin
          in_gap          <= in_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
          in_gap          <= $urandom_range(0, 17);
          s_axis_tvalid_i <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          s_axis_tdata_i  <= pixel_queue.pop_front();
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: result beats come back in the order the pixels went in.
  always @(posedge clk_i or negedge rst_ni) begin
    escape_t got;
    escape_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      out_gap         <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = escape_t'(m_axis_tdata_o[41:0]);
        if (escape_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result beat: col %0d row %0d iters %0d esc %0d",
                     got.col, got.row, got.iters, got.esc);
          end
        end else begin
          want = escape_queue.pop_front();
          if (want != got || m_axis_tdata_o[47:42] != '0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected col %0d row %0d iters %0d esc %0d",
                       want.col, want.row, want.iters, want.esc);
              $display("          got col %0d row %0d iters %0d esc %0d pad %h",
                       got.col, got.row, got.iters, got.esc, m_axis_tdata_o[47:42]);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap         <= out_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_gap         <= $urandom_range(0, 17);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Register write over the configuration port, mirrored into the local copy.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      mbe_pkg::RegOriginRe: org_re     = value;
      mbe_pkg::RegOriginIm: org_im     = value;
      mbe_pkg::RegStepRe:   stp_re     = value;
      mbe_pkg::RegStepIm:   stp_im     = value;
      mbe_pkg::RegLimit:    iter_limit = value[mbe_pkg::LimW-1:0];
      mbe_pkg::RegRadius:   radius_sq  = value[mbe_pkg::RadW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] ore, logic [31:0] oim, logic [31:0] sre,
                           logic [31:0] sim, logic [31:0] lim, logic [31:0] rad);
    write_reg(mbe_pkg::RegOriginRe, ore);
    write_reg(mbe_pkg::RegOriginIm, oim);
    write_reg(mbe_pkg::RegStepRe, sre);
    write_reg(mbe_pkg::RegStepIm, sim);
    write_reg(mbe_pkg::RegLimit, lim);
    write_reg(mbe_pkg::RegRadius, rad);
  endtask

  // Wait until every queued pixel has been accepted and every result has come back.
  task automatic drain();
    while (pixel_queue.size() > 0 || s_axis_tvalid_i || escape_queue.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
  endtask

  task automatic add_random(int count);
    for (int k = 0; k < count; k++) begin
      pixel_queue.push_back(pixel_t'(24'($urandom_range(0, 24'hFF_FFFF))));
    end
  endtask

  task automatic add_pixel(int c, int r);
    pixel_t px;
    px.col = c[11:0];
    px.row = r[11:0];
    pixel_queue.push_back(px);
  endtask

  // Random settings, mostly framing the interesting part of the plane.
  task automatic random_config();
    logic [31:0] ore, oim, sre, sim, rad;
    if ($urandom_range(0, 3) == 0) begin
      ore = $urandom();
      oim = $urandom();
      sre = $urandom();
      sim = $urandom();
    end else begin
      ore = $urandom_range(0, 32'h1800_0000) - 32'h1000_0000;
      oim = $urandom_range(0, 32'h1800_0000) - 32'h0C00_0000;
      sre = $urandom_range(0, 32'h0010_0000);
      sim = $urandom_range(0, 32'h0010_0000);
      if ($urandom_range(0, 1)) sre = -sre;
      if ($urandom_range(0, 1)) sim = -sim;
    end
    rad = ($urandom_range(0, 1)) ? 32'h2000_0000 : $urandom_range(0, 32'h7FFF_FFFF);
    write_all(ore, oim, sre, sim, $urandom_range(0, 48), rad);
  endtask

  // Stimulus sequence.
  initial begin
    org_re     = mbe_pkg::RstOriginRe;
    org_im     = mbe_pkg::RstOriginIm;
    stp_re     = mbe_pkg::RstStepRe;
    stp_im     = mbe_pkg::RstStepIm;
    iter_limit = mbe_pkg::RstLimit;
    radius_sq  = mbe_pkg::RstRadius;
    mismatches = 0;
    no_idle    = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_ni     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: corners, bit patterns, and points inside the set.
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(0, 4095);
    add_pixel(4095, 0);
    add_pixel(1023, 1023);
    add_pixel(512, 512);
    add_pixel(256, 512);
    add_pixel(600, 500);
    add_pixel(12'hAAA, 12'h555);
    add_pixel(12'h555, 12'hAAA);
    add_random(200);
    drain();

    // Zero limit and zero radius: the origin never escapes, all else at once.
    write_all(32'h0, 32'h0, 32'h0000_1000, 32'h0000_1000, 32'd0, 32'd0);
    add_pixel(0, 0);
    add_pixel(1, 0);
    add_pixel(4095, 4095);
    add_random(15);
    drain();

    // Widest radius with saturating points at the negative extreme.
    write_all(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd16,
              32'h7FFF_FFFF);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(1, 1);
    add_random(25);
    drain();

    // Positive extreme origin with the most negative step.
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd8,
              32'h2000_0000);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(1, 0);
    add_random(25);
    drain();

    // Largest limit: a few pixels inside the set run for the full count.
    write_all(mbe_pkg::RstOriginRe, mbe_pkg::RstOriginIm, mbe_pkg::RstStepRe,
              mbe_pkg::RstStepIm, 32'd65535, 32'(mbe_pkg::RstRadius));
    add_pixel(512, 512);
    add_pixel(0, 0);
    add_pixel(400, 512);
    drain();

    // Random settings.
    for (int p = 0; p < 12; p++) begin
      random_config();
      add_random(40);
      drain();
    end

    // Last part without idling on either side.
    no_idle = 1'b1;
    write_all(mbe_pkg::RstOriginRe, mbe_pkg::RstOriginIm, mbe_pkg::RstStepRe,
              mbe_pkg::RstStepIm, 32'd32, 32'(mbe_pkg::RstRadius));
    add_random(100);
    drain();

    if (mismatches == 0 && escape_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- mandelbrot_escape_time_unit.f -----
rtl/core/mbe_pkg.sv
rtl/core/mbe_point.sv
rtl/core/mbe_ring.sv
rtl/core/mandelbrot_escape_time_unit.sv
rtl/core/mbe_checker.sv
test/mandelbrot_escape_time_unit_tb.sv
